FILE: sv/fpfb_pkg.sv
// ----------------------------------------------------------------------------
// fpfb_pkg
// Shared types, codes and default sizes of the focal plane flux binner.
// ----------------------------------------------------------------------------
package fpfb_pkg;

    // Default map geometry
    localparam int SUBFIELD_WIDTH_DEF      = 24;
    localparam int SUBFIELD_HEIGHT_DEF     = 24;
    localparam int EDGE_PIXELS_DEF         = 4;
    localparam int SUBPIXELS_PER_PIXEL_DEF = 4;

    // Request codes
    localparam logic [1:0] REQ_ADD_POINT = 2'd0;
    localparam logic [1:0] REQ_ADD_ALL   = 2'd1;
    localparam logic [1:0] REQ_READ_CELL = 2'd2;

    // Configuration register indexes
    localparam int          CFG_IDX_W     = 3;
    localparam logic [2:0]  CFG_ORIGIN_X  = 3'd0;
    localparam logic [2:0]  CFG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0]  CFG_INV_PIX   = 3'd2;
    localparam logic [2:0]  CFG_COS       = 3'd3;
    localparam logic [2:0]  CFG_SIN       = 3'd4;
    localparam logic [2:0]  CFG_ZERO_X    = 3'd5;
    localparam logic [2:0]  CFG_ZERO_Y    = 3'd6;

    localparam int CELL_W = 48;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic        [23:0] inv_pixel_size;
        logic signed [17:0] cos_orient;
        logic signed [17:0] sin_orient;
        logic signed [31:0] zero_x;
        logic signed [31:0] zero_y;
    } fpfb_cfg_t;

endpackage

FILE: sv/fpfb_map_mem.sv
// ----------------------------------------------------------------------------
// fpfb_map_mem
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fpfb_map_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 48
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/fpfb_xform.sv
// ----------------------------------------------------------------------------
// fpfb_xform
// Four-stage point transform: offset and scale, rotate, shift, cell lookup.
// ----------------------------------------------------------------------------
module fpfb_xform
    import fpfb_pkg::*;
#(
    parameter int MAP_W               = 128,
    parameter int MAP_H               = 128,
    parameter int EDGE_PIXELS         = EDGE_PIXELS_DEF,
    parameter int SUBPIXELS_PER_PIXEL = SUBPIXELS_PER_PIXEL_DEF,
    parameter int CW                  = 7,
    parameter int RW                  = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  fpfb_cfg_t          cfg,
    input  logic               in_valid,
    input  logic signed [31:0] x_mm,
    input  logic signed [31:0] y_mm,
    output logic               out_valid,
    output logic               out_hit,
    output logic [RW-1:0]      out_row,
    output logic [CW-1:0]      out_col
);

    localparam logic signed [61:0] EDGE_TERM = 62'(EDGE_PIXELS) <<< 32;
    localparam logic signed [61:0] CLAMP_LIM = 62'sd1 <<< 58;

    logic [3:0] vld_reg;

    // stage 1
    logic signed [32:0] dx, dy;
    logic signed [57:0] px, py;
    logic signed [41:0] xp_reg, yp_reg;
    // stage 2
    logic signed [59:0] xc_reg, ys_reg, xs_reg, yc_reg;
    // stage 3
    logic signed [61:0] zx_term, zy_term;
    logic signed [61:0] col_next, row_next;
    logic signed [61:0] col_reg, row_reg;
    // stage 4
    logic [32:0] col_cell, row_cell;
    logic          hit_reg;
    logic [RW-1:0] row_reg_c;
    logic [CW-1:0] col_reg_c;

    function automatic logic [32:0] to_cell(input logic signed [61:0] v,
                                            input logic [31:0] limit);
        logic [58:0] vc;
        logic [63:0] sc;
        vc = (v > CLAMP_LIM) ? CLAMP_LIM[58:0] : v[58:0];
        sc = 64'(vc) * 64'(SUBPIXELS_PER_PIXEL);
        to_cell = {(!v[61]) && (sc[63:32] < limit), sc[63:32]};
    endfunction

    assign dx = $signed({x_mm[31], x_mm}) - $signed({cfg.origin_x[31], cfg.origin_x});
    assign dy = $signed({y_mm[31], y_mm}) - $signed({cfg.origin_y[31], cfg.origin_y});
    assign px = dx * $signed({1'b0, cfg.inv_pixel_size});
    assign py = dy * $signed({1'b0, cfg.inv_pixel_size});

    assign zx_term  = $signed({{14{cfg.zero_x[31]}}, cfg.zero_x, 16'b0});
    assign zy_term  = $signed({{14{cfg.zero_y[31]}}, cfg.zero_y, 16'b0});
    assign col_next = 62'(xc_reg) - 62'(ys_reg) - zx_term + EDGE_TERM;
    assign row_next = 62'(xs_reg) + 62'(yc_reg) - zy_term + EDGE_TERM;

    assign col_cell = to_cell(col_reg, 32'(MAP_W));
    assign row_cell = to_cell(row_reg, 32'(MAP_H));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        // floor to Q.16 pixels
        xp_reg <= px[57:16];
        yp_reg <= py[57:16];
        xc_reg <= xp_reg * $signed(cfg.cos_orient);
        ys_reg <= yp_reg * $signed(cfg.sin_orient);
        xs_reg <= xp_reg * $signed(cfg.sin_orient);
        yc_reg <= yp_reg * $signed(cfg.cos_orient);
        col_reg <= col_next;
        row_reg <= row_next;
        hit_reg   <= col_cell[32] && row_cell[32];
        row_reg_c <= row_cell[RW-1:0];
        col_reg_c <= col_cell[CW-1:0];
    end

    assign out_valid = vld_reg[3];
    assign out_hit   = hit_reg;
    assign out_row   = row_reg_c;
    assign out_col   = col_reg_c;

endmodule

FILE: sv/focal_plane_flux_binner_core.sv
// ----------------------------------------------------------------------------
// focal_plane_flux_binner_core
// Bins flux samples at focal-plane points into a 2-D sub-pixel map.
// ----------------------------------------------------------------------------
// One word is handled at a time. After reset the block clears all MAP_W*MAP_H
// map cells (16384 at default sizes) with s_ready low; configuration writes
// are taken throughout. A point add that lands in the map passes through the
// four transform stages, one map read and one write-back before its result is
// loaded; one that misses the map skips the map read and write-back. A cell
// read waits on the map read; an add-to-all, a read outside the map or an
// unused code goes straight to the result. A new word is accepted while the
// previous result still waits on the m_ side.
module focal_plane_flux_binner_core
    import fpfb_pkg::*;
#(
    parameter int SUBFIELD_WIDTH      = SUBFIELD_WIDTH_DEF,
    parameter int SUBFIELD_HEIGHT     = SUBFIELD_HEIGHT_DEF,
    parameter int EDGE_PIXELS         = EDGE_PIXELS_DEF,
    parameter int SUBPIXELS_PER_PIXEL = SUBPIXELS_PER_PIXEL_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_req_type,
    input  logic signed [31:0]   s_x_mm,
    input  logic signed [31:0]   s_y_mm,
    input  logic signed [31:0]   s_flux,
    input  logic [6:0]           s_read_row,
    input  logic [6:0]           s_read_col,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_in_map,
    output logic [6:0]           m_hit_row,
    output logic [6:0]           m_hit_col,
    output logic signed [47:0]   m_cell_value
);

    localparam int MAP_W = (SUBFIELD_WIDTH + 2 * EDGE_PIXELS) * SUBPIXELS_PER_PIXEL;
    localparam int MAP_H = (SUBFIELD_HEIGHT + 2 * EDGE_PIXELS) * SUBPIXELS_PER_PIXEL;
    localparam int DEPTH = MAP_W * MAP_H;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAP_W > 1) ? $clog2(MAP_W) : 1;
    localparam int RW    = (MAP_H > 1) ? $clog2(MAP_H) : 1;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_XFORM = 5'b00100,
        ST_READ  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    fpfb_cfg_t cfg_reg;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [1:0]    req_reg;
    logic [31:0]   flux_reg;
    logic [AW-1:0] addr_reg, addr_next;
    logic [CELL_W-1:0] bias_reg, bias_next;

    logic              res_in_map_reg, res_in_map_next;
    logic [6:0]        res_row_reg, res_row_next;
    logic [6:0]        res_col_reg, res_col_next;
    logic [CELL_W-1:0] res_cv_reg, res_cv_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_in_map_reg;
    logic [6:0]        m_row_reg;
    logic [6:0]        m_col_reg;
    logic [CELL_W-1:0] m_cv_reg;

    logic s_accept;
    logic out_free;

    logic          xf_valid, xf_hit;
    logic [RW-1:0] xf_row;
    logic [CW-1:0] xf_col;
    logic [31:0]   pt_idx, rd_idx, xf_row32, xf_col32;
    logic          rd_in_map;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata, mem_rdata;
    logic [CELL_W-1:0] flux48;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign flux48    = {{16{flux_reg[31]}}, flux_reg};
    assign pt_idx    = 32'(xf_row) * 32'(MAP_W) + 32'(xf_col);
    assign rd_idx    = 32'(s_read_row) * 32'(MAP_W) + 32'(s_read_col);
    assign rd_in_map = (32'(s_read_row) < 32'(MAP_H)) && (32'(s_read_col) < 32'(MAP_W));
    assign xf_row32  = 32'(xf_row);
    assign xf_col32  = 32'(xf_col);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x       <= '0;
            cfg_reg.origin_y       <= '0;
            cfg_reg.inv_pixel_size <= 24'd65536;
            cfg_reg.cos_orient     <= 18'sd65536;
            cfg_reg.sin_orient     <= '0;
            cfg_reg.zero_x         <= '0;
            cfg_reg.zero_y         <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ORIGIN_X: cfg_reg.origin_x       <= cfg_data;
                CFG_ORIGIN_Y: cfg_reg.origin_y       <= cfg_data;
                CFG_INV_PIX:  cfg_reg.inv_pixel_size <= cfg_data[23:0];
                CFG_COS:      cfg_reg.cos_orient     <= cfg_data[17:0];
                CFG_SIN:      cfg_reg.sin_orient     <= cfg_data[17:0];
                CFG_ZERO_X:   cfg_reg.zero_x         <= cfg_data;
                CFG_ZERO_Y:   cfg_reg.zero_y         <= cfg_data;
                default: ;
            endcase
        end
    end

    fpfb_xform #(
        .MAP_W               (MAP_W),
        .MAP_H               (MAP_H),
        .EDGE_PIXELS         (EDGE_PIXELS),
        .SUBPIXELS_PER_PIXEL (SUBPIXELS_PER_PIXEL),
        .CW                  (CW),
        .RW                  (RW)
    ) u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_accept && (s_req_type == REQ_ADD_POINT)),
        .x_mm      (s_x_mm),
        .y_mm      (s_y_mm),
        .out_valid (xf_valid),
        .out_hit   (xf_hit),
        .out_row   (xf_row),
        .out_col   (xf_col)
    );

    fpfb_map_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (CELL_W)
    ) u_map_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        addr_next       = addr_reg;
        bias_next       = bias_reg;
        res_in_map_next = res_in_map_reg;
        res_row_next    = res_row_reg;
        res_col_next    = res_col_reg;
        res_cv_next     = res_cv_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = mem_rdata + flux48;
        mem_re          = 1'b0;
        mem_raddr       = rd_idx[AW-1:0];

        case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    res_in_map_next = 1'b0;
                    res_row_next    = '0;
                    res_col_next    = '0;
                    res_cv_next     = '0;
                    state_next      = ST_OUT;
                    case (s_req_type)
                        REQ_ADD_POINT: state_next = ST_XFORM;
                        REQ_ADD_ALL: begin
                            bias_next = bias_reg + {{16{s_flux[31]}}, s_flux};
                        end
                        REQ_READ_CELL: begin
                            if (rd_in_map) begin
                                mem_re     = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_XFORM: begin
                if (xf_valid) begin
                    if (xf_hit) begin
                        mem_re          = 1'b1;
                        mem_raddr       = pt_idx[AW-1:0];
                        addr_next       = pt_idx[AW-1:0];
                        res_in_map_next = 1'b1;
                        res_row_next    = xf_row32[6:0];
                        res_col_next    = xf_col32[6:0];
                        state_next      = ST_READ;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_READ: begin
                // write back the sum for a point add, report cell plus bias for a read
                if (req_reg == REQ_ADD_POINT) begin
                    mem_we = 1'b1;
                end else begin
                    res_in_map_next = 1'b1;
                    res_cv_next     = mem_rdata + bias_reg;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            bias_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            bias_reg    <= bias_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg  <= s_req_type;
            flux_reg <= s_flux;
        end
        addr_reg       <= addr_next;
        res_in_map_reg <= res_in_map_next;
        res_row_reg    <= res_row_next;
        res_col_reg    <= res_col_next;
        res_cv_reg     <= res_cv_next;
        if ((state_reg == ST_OUT) && out_free) begin
            m_in_map_reg <= res_in_map_reg;
            m_row_reg    <= res_row_reg;
            m_col_reg    <= res_col_reg;
            m_cv_reg     <= res_cv_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_in_map     = m_in_map_reg;
    assign m_hit_row    = m_row_reg;
    assign m_hit_col    = m_col_reg;
    assign m_cell_value = m_cv_reg;

`ifndef SYNTH
    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("input accepted during map clear");

    a_xform_only_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        xf_valid |-> (state_reg == ST_XFORM))
        else $error("transform result outside transform wait");

    a_point_to_xform: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_req_type == REQ_ADD_POINT)) |=> (state_reg == ST_XFORM))
        else $error("point add did not enter transform");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_IDLE) || (state_reg == ST_OUT)) |-> !mem_we)
        else $error("map written outside clear or write-back");
`endif

endmodule
